// ----- rtl/tte_pkg.sv -----
// shared types and constants of the transposition table engine
package tte_pkg;

  localparam int KEY_W = 64;
  localparam int MOVE_W = 25;
  localparam int SCORE_W = 16;
  localparam int PLY_W = 6;
  localparam int DEPTH_W = 6;
  localparam int KIND_W = 2;
  localparam int AGE_W = 8;
  localparam int THR_W = 15;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_MATE_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_AGE = 1'b1;

  localparam logic [THR_W-1:0] MATE_THRESHOLD_RESET = 15'd29000;
  localparam logic [AGE_W-1:0] AGE_RESET = 8'd0;

  localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BETA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIGIT_W = 4;
  localparam int DIGITS = KEY_W / DIGIT_W;
  localparam int STEP_W = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {
    CMD_PROBE      = 2'd0,
    CMD_STORE      = 2'd1,
    CMD_MOVE_PROBE = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_CLEAR,
    ST_CLEAR_DONE
  } back_state_t;

  typedef struct packed {
    cmd_t                       command;
    logic [KEY_W-1:0]           key;
    logic [PLY_W-1:0]           ply;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic [MOVE_W-1:0]          move;
    logic signed [SCORE_W-1:0]  score;
    logic [KIND_W-1:0]          kind;
  } item_t;

  typedef struct packed {
    logic [MOVE_W-1:0]          move;
    logic signed [SCORE_W-1:0]  score;
    logic [DEPTH_W-1:0]         depth;
    logic [KIND_W-1:0]          kind;
    logic [AGE_W-1:0]           age;
  } entry_t;

endpackage

// ----- rtl/tte_ram.sv -----
// generic single-write, single-read ram with registered read data
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tte_queue.sv -----
// small fifo between the front and the back
module tte_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tte_front.sv -----
// front end: takes requests, clamps ply and reduces the key to a table index
module tte_front #(
  parameter int ENTRIES = 4096,
  parameter int MAX_PLY = 64,
  parameter int IDX_W = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              init_busy,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic [tte_pkg::KEY_W-1:0]         position_key,
  input  logic [tte_pkg::PLY_W-1:0]         ply,
  input  logic [tte_pkg::DEPTH_W-1:0]       search_depth,
  input  logic signed [tte_pkg::SCORE_W-1:0] alpha,
  input  logic signed [tte_pkg::SCORE_W-1:0] beta,
  input  logic [tte_pkg::MOVE_W-1:0]        best_move,
  input  logic signed [tte_pkg::SCORE_W-1:0] score_in,
  input  logic [tte_pkg::KIND_W-1:0]        bound_kind,
  output logic                              push_valid,
  input  logic                              push_ready,
  output tte_pkg::item_t                    push_item,
  output logic [IDX_W-1:0]                  push_idx
);

  import tte_pkg::*;

  localparam bit POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam int PLY_CAP = MAX_PLY - 1;
  localparam int REM_W = IDX_W + 1;
  localparam logic [REM_W-1:0] ENTRIES_R = REM_W'(ENTRIES);

  item_t             hold;
  logic              hold_valid;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [KEY_W-1:0]  shift;
  logic [STEP_W-1:0] steps;
  logic              done;
  logic              in_accept;
  logic [PLY_W-1:0]  ply_sat;

  assign done = (steps == '0);
  assign push_valid = hold_valid && done;
  assign push_item = hold;
  assign push_idx = rem[IDX_W-1:0];
  assign in_stall = init_busy || (hold_valid && !(done && push_ready));
  assign in_accept = in_valid && !in_stall;
  assign ply_sat = (int'(ply) > PLY_CAP) ? PLY_W'(PLY_CAP) : ply;

  // four remainder steps per cycle, msb first
  always_comb begin
    logic [REM_W-1:0] r;
    r = rem;
    for (int k = 0; k < DIGIT_W; k++) begin
      r = {r[REM_W-2:0], shift[KEY_W-1-k]};
      if (r >= ENTRIES_R) begin
        r = r - ENTRIES_R;
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold.command <= cmd_t'(command);
      hold.key <= position_key;
      hold.ply <= ply_sat;
      hold.depth <= search_depth;
      hold.alpha <= alpha;
      hold.beta <= beta;
      hold.move <= best_move;
      hold.score <= score_in;
      hold.kind <= bound_kind;
      shift <= position_key;
    end else if (!done) begin
      shift <= shift << DIGIT_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      steps <= '0;
      rem <= '0;
    end else begin
      if (in_accept) begin
        hold_valid <= 1'b1;
        if (POW2) begin
          rem <= {1'b0, position_key[IDX_W-1:0]};
          steps <= '0;
        end else begin
          rem <= '0;
          steps <= STEP_W'(DIGITS);
        end
      end else begin
        if (push_valid && push_ready) begin
          hold_valid <= 1'b0;
        end
        if (!done) begin
          rem <= rem_next;
          steps <= steps - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/tte_back.sv -----
// back end: table memories, lookup and replacement, clear sweep, result register
module tte_back #(
  parameter int ENTRIES = 4096,
  parameter int IDX_W = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [tte_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  tte_pkg::item_t                        q_item,
  input  logic [IDX_W-1:0]                      q_idx,
  output logic                                  init_busy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  key_found,
  output logic                                  cutoff_hit,
  output logic [tte_pkg::MOVE_W-1:0]            move_out,
  output logic signed [tte_pkg::SCORE_W-1:0]    score_out,
  output logic                                  stored
);

  import tte_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam int ENTRY_W = $bits(entry_t);

  back_state_t       state;
  back_state_t       state_next;
  item_t             cur;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  sweep;
  logic              sweep_last;
  logic [THR_W-1:0]  mate_threshold;
  logic [AGE_W-1:0]  current_age;

  logic              out_free;
  logic              ram_we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [KEY_W-1:0]  key_wdata;
  logic [ENTRY_W-1:0] entry_wdata;
  logic [KEY_W-1:0]  key_rdata;
  logic [ENTRY_W-1:0] entry_rdata;
  logic              load_result;
  logic              load_zero;

  entry_t            e;
  entry_t            e_new;
  logic              match;
  logic              replace;
  logic              res_found;
  logic              res_hit;
  logic signed [SCORE_W-1:0] res_score;
  logic signed [16:0] thr17;
  logic signed [16:0] ply17;
  logic signed [16:0] s17;
  logic signed [16:0] adj17;
  logic signed [16:0] in17;
  logic signed [16:0] st17;
  logic signed [16:0] alpha17;
  logic signed [16:0] beta17;

  tte_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  tte_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (entry_wdata),
    .raddr (raddr),
    .rdata (entry_rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign sweep_last = (sweep == IDX_LAST);

  // lookup and replacement arithmetic
  always_comb begin
    e = entry_t'(entry_rdata);
    match = (key_rdata == cur.key);
    thr17 = {2'b00, mate_threshold};
    ply17 = {11'd0, cur.ply};
    s17 = {e.score[SCORE_W-1], e.score};
    alpha17 = {cur.alpha[SCORE_W-1], cur.alpha};
    beta17 = {cur.beta[SCORE_W-1], cur.beta};
    in17 = {cur.score[SCORE_W-1], cur.score};

    if (s17 > thr17) begin
      adj17 = s17 - ply17;
    end else if (s17 < -thr17) begin
      adj17 = s17 + ply17;
    end else begin
      adj17 = s17;
    end

    res_found = ((cur.command == CMD_PROBE) || (cur.command == CMD_MOVE_PROBE)) && match;
    res_hit = 1'b0;
    res_score = '0;
    if (res_found && (cur.command == CMD_PROBE) && (e.depth >= cur.depth)) begin
      case (e.kind)
        KIND_ALPHA: begin
          if (adj17 <= alpha17) begin
            res_hit = 1'b1;
            res_score = cur.alpha;
          end
        end
        KIND_BETA: begin
          if (adj17 >= beta17) begin
            res_hit = 1'b1;
            res_score = cur.beta;
          end
        end
        KIND_EXACT: begin
          res_hit = 1'b1;
          res_score = adj17[SCORE_W-1:0];
        end
        default: begin
          res_hit = 1'b0;
        end
      endcase
    end

    replace = (cur.command == CMD_STORE) &&
              ((key_rdata == '0) || (e.age < current_age) || (e.depth <= cur.depth));

    if (in17 > thr17) begin
      st17 = in17 + ply17;
    end else if (in17 < -thr17) begin
      st17 = in17 - ply17;
    end else begin
      st17 = in17;
    end
    e_new.move = cur.move;
    if (st17 > 17'sd32767) begin
      e_new.score = 16'sh7fff;
    end else if (st17 < -17'sd32768) begin
      e_new.score = 16'sh8000;
    end else begin
      e_new.score = st17[SCORE_W-1:0];
    end
    e_new.depth = cur.depth;
    e_new.kind = cur.kind;
    e_new.age = current_age;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.command == CMD_CLEAR) ? ST_CLEAR : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (sweep_last) state_next = ST_CLEAR_DONE;
      end
      ST_CLEAR_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_ready = 1'b0;
    ram_we = 1'b0;
    waddr = cur_idx;
    raddr = cur_idx;
    key_wdata = cur.key;
    entry_wdata = e_new;
    load_result = 1'b0;
    load_zero = 1'b0;
    init_busy = (state == ST_INIT);
    case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        waddr = sweep;
        key_wdata = '0;
        entry_wdata = '0;
      end
      ST_IDLE: begin
        raddr = q_idx;
        q_ready = q_valid;
      end
      ST_LOOK: begin
        if (out_free) begin
          load_result = 1'b1;
          ram_we = replace;
        end
      end
      ST_CLEAR_DONE: begin
        load_zero = out_free;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      cur <= q_item;
      cur_idx <= q_idx;
    end
    if (load_result) begin
      key_found <= res_found;
      cutoff_hit <= res_hit;
      move_out <= res_found ? e.move : '0;
      score_out <= res_score;
      stored <= replace;
    end else if (load_zero) begin
      key_found <= 1'b0;
      cutoff_hit <= 1'b0;
      move_out <= '0;
      score_out <= '0;
      stored <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      out_valid <= 1'b0;
      mate_threshold <= MATE_THRESHOLD_RESET;
      current_age <= AGE_RESET;
    end else begin
      state <= state_next;
      if ((state == ST_INIT) || (state == ST_CLEAR)) begin
        sweep <= sweep_last ? '0 : sweep + 1'b1;
      end
      if (load_result || load_zero) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_CLEAR) && sweep_last) begin
        current_age <= AGE_RESET;
      end else if (cfg_write_en && (cfg_index == REG_CURRENT_AGE)) begin
        current_age <= cfg_data[AGE_W-1:0];
      end
      if (cfg_write_en && (cfg_index == REG_MATE_THRESHOLD)) begin
        mate_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  a_hit_needs_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && cutoff_hit |-> key_found)
    else $error("cutoff hit without key match");

  a_store_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored |-> !key_found && !cutoff_hit && (move_out == '0))
    else $error("store result carries probe fields");

  a_no_pop_during_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) || (state == ST_CLEAR) |-> !q_ready)
    else $error("queue popped during sweep");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != ST_IDLE) && (state != ST_CLEAR_DONE))
    else $error("table write in idle state");

  a_result_after_look: assert property (@(posedge clk) disable iff (rst)
    $past(load_result) |-> out_valid)
    else $error("lookup result lost");

endmodule

// ----- rtl/transposition_table_engine.sv -----
// top level of the transposition table engine
//
// requests come in on in_valid/in_stall with command, key, ply, depth, bounds,
// move, score and bound kind; one result per request leaves on
// out_valid/out_stall. the config port writes mate_threshold (index 0) and
// current_age (index 1) when cfg_write_en is high.
// the front end registers a request and reduces the key to a table index:
// the low key bits when ENTRIES is a power of two, otherwise a serial
// remainder, four bits per cycle. a two-entry queue feeds the back end.
// probes and stores pass two back-end states: ST_IDLE pops the request and
// reads the key and entry memories, ST_LOOK compares, builds the result and
// writes the entry if a store replaces it; ST_LOOK waits while the result
// register is held. the front end takes a new request while the back end
// still works on an earlier one. ST_LOOK sets out_valid with the result.
// a clear walks every table row, holding the back end, and resets current_age.
// after reset the same sweep runs with in_stall held high; config writes are
// taken during that time.
// while out_valid and out_stall are high the result register holds its value
// and the back end waits; front end and queue keep taking requests until full.
module transposition_table_engine #(
  parameter int ENTRIES = 4096,
  parameter int MAX_PLY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [tte_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            command,
  input  logic [tte_pkg::KEY_W-1:0]             position_key,
  input  logic [tte_pkg::PLY_W-1:0]             ply,
  input  logic [tte_pkg::DEPTH_W-1:0]           search_depth,
  input  logic signed [tte_pkg::SCORE_W-1:0]    alpha,
  input  logic signed [tte_pkg::SCORE_W-1:0]    beta,
  input  logic [tte_pkg::MOVE_W-1:0]            best_move,
  input  logic signed [tte_pkg::SCORE_W-1:0]    score_in,
  input  logic [tte_pkg::KIND_W-1:0]            bound_kind,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  key_found,
  output logic                                  cutoff_hit,
  output logic [tte_pkg::MOVE_W-1:0]            move_out,
  output logic signed [tte_pkg::SCORE_W-1:0]    score_out,
  output logic                                  stored
);

  import tte_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int Q_W = $bits(item_t) + IDX_W;

  logic              init_busy;
  logic              push_valid;
  logic              push_ready;
  item_t             push_item;
  logic [IDX_W-1:0]  push_idx;
  logic              pop_valid;
  logic              pop_ready;
  logic [Q_W-1:0]    pop_data;
  item_t             pop_item;
  logic [IDX_W-1:0]  pop_idx;

  assign pop_item = item_t'(pop_data[Q_W-1:IDX_W]);
  assign pop_idx = pop_data[IDX_W-1:0];

  tte_front #(
    .ENTRIES (ENTRIES),
    .MAX_PLY (MAX_PLY),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .init_busy    (init_busy),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .position_key (position_key),
    .ply          (ply),
    .search_depth (search_depth),
    .alpha        (alpha),
    .beta         (beta),
    .best_move    (best_move),
    .score_in     (score_in),
    .bound_kind   (bound_kind),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item),
    .push_idx     (push_idx)
  );

  tte_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_item, push_idx}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tte_back #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (pop_valid),
    .q_ready      (pop_ready),
    .q_item       (pop_item),
    .q_idx        (pop_idx),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_found    (key_found),
    .cutoff_hit   (cutoff_hit),
    .move_out     (move_out),
    .score_out    (score_out),
    .stored       (stored)
  );

endmodule
